// ===== sv/hta_pkg.sv =====
// shared constants, codes and types of the handle table allocator
package hta_pkg;

   localparam int TABLE_DEPTH  = 16;
   localparam int HANDLE_WIDTH = 31;
   localparam int PAYLOAD_W    = 32;
   localparam int SIZE_W       = 16;
   localparam int OPCODE_W     = 2;
   localparam int STATUS_W     = 2;
   localparam int MAX_W        = 5;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > MAX_W) ? CNT_W : MAX_W;

   localparam int DATA_BITS = HANDLE_WIDTH + PAYLOAD_W + SIZE_W;
   localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;
   localparam int ENTRY_W   = PAYLOAD_W + SIZE_W;

   localparam logic [MAX_W-1:0] MAX_ENTRIES_RST = MAX_W'(TABLE_DEPTH);

   localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STS_EXHAUSTED = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_READ = 4'b0100,
      ST_RESP = 4'b1000
   } hta_state_type;

   typedef struct packed {
      logic                    start;
      logic                    free_mode;
      logic [HANDLE_WIDTH-1:0] key;
      logic                    set;
      logic                    clr;
      logic [IDX_W-1:0]        slot;
      logic [HANDLE_WIDTH-1:0] set_handle;
   } hta_scan_cmd_type;

   typedef struct packed {
      logic             done;
      logic             hit;
      logic [IDX_W-1:0] slot;
   } hta_scan_sts_type;

endpackage

// ===== sv/handle_table_allocator_core.sv =====
// handle table allocator top level: sequencer, counters, entry ram and result register
//
//   channel  dir  tdata / data                         tuser
//   req_     in   handle, payload, payload_size        opcode
//   rsp_     out  result_handle, result_payload, size  status
//   csr_     in   max_entries (write only)             -
//
// the scan comparator looks at one slot per cycle and stops at the first match
// lookup hits pass through the read state for the registered entry ram read
// reset is synchronous; it clears all valid bits, the handle counter and the live count
// the next beat can be taken as soon as the response is in the output register
// a response still held in the output register stalls the sequencer in its resp state
module handle_table_allocator_core
   import hta_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,   // handle, payload, payload_size
   input  logic [OPCODE_W-1:0]  req_tuser,   // opcode
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,   // result_handle, result_payload, result_size
   output logic [STATUS_W-1:0]  rsp_tuser,   // status
   input  logic                 csr_wr_en,
   input  logic [MAX_W-1:0]     csr_wr_data  // max_entries
);

   localparam int PL_LO = HANDLE_WIDTH;
   localparam int SZ_LO = HANDLE_WIDTH + PAYLOAD_W;

   hta_state_type           state_ff, state_in;
   logic [MAX_W-1:0]        max_entries_ff, max_entries_in;
   logic [HANDLE_WIDTH-1:0] last_handle_ff, last_handle_in;
   logic [CNT_W-1:0]        live_count_ff, live_count_in;
   logic [OPCODE_W-1:0]     op_ff, op_in;
   logic [PAYLOAD_W-1:0]    in_payload_ff, in_payload_in;
   logic [SIZE_W-1:0]       in_size_ff, in_size_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [HANDLE_WIDTH-1:0] res_handle_ff, res_handle_in;
   logic [PAYLOAD_W-1:0]    res_payload_ff, res_payload_in;
   logic [SIZE_W-1:0]       res_size_ff, res_size_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TDATA_W-1:0]      rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   hta_scan_cmd_type scan_cmd;
   hta_scan_sts_type scan_sts;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [ENTRY_W-1:0] ram_rd_data;

   logic req_fire;
   logic table_full;
   logic handles_used;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign table_full   = CMP_W'(live_count_ff) >= CMP_W'(max_entries_ff);
   assign handles_used = (last_handle_ff == '1);

   hta_scan u_scan (
      .clock (clock),
      .reset (reset),
      .cmd   (scan_cmd),
      .sts   (scan_sts)
   );

   hta_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (scan_sts.slot),
      .wr_data ({in_size_ff, in_payload_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_sts.slot),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      max_entries_in = csr_wr_en ? csr_wr_data : max_entries_ff;
      last_handle_in = last_handle_ff;
      live_count_in  = live_count_ff;
      op_in          = op_ff;
      in_payload_in  = in_payload_ff;
      in_size_in     = in_size_ff;
      res_status_in  = res_status_ff;
      res_handle_in  = res_handle_ff;
      res_payload_in = res_payload_ff;
      res_size_in    = res_size_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_status_in  = rsp_status_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;

      scan_cmd            = '0;
      scan_cmd.slot       = scan_sts.slot;
      scan_cmd.set_handle = last_handle_ff + 1'b1;
      scan_cmd.key        = req_tdata[HANDLE_WIDTH-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in          = req_tuser;
               in_payload_in  = req_tdata[PL_LO +: PAYLOAD_W];
               in_size_in     = req_tdata[SZ_LO +: SIZE_W];
               res_status_in  = STS_NOT_FOUND;
               res_handle_in  = '0;
               res_payload_in = '0;
               res_size_in    = '0;
               unique case (req_tuser)
                  OP_ADD: begin
                     priority if (table_full) begin
                        res_status_in = STS_FULL;
                        state_in      = ST_RESP;
                     end else if (handles_used) begin
                        res_status_in = STS_EXHAUSTED;
                        state_in      = ST_RESP;
                     end else begin
                        scan_cmd.start     = 1'b1;
                        scan_cmd.free_mode = 1'b1;
                        state_in           = ST_SCAN;
                     end
                  end
                  OP_REMOVE, OP_LOOKUP: begin
                     scan_cmd.start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_sts.done) begin
               state_in = ST_RESP;
               unique case (op_ff)
                  OP_ADD: begin
                     if (scan_sts.hit) begin
                        ram_wr_en      = 1'b1;
                        scan_cmd.set   = 1'b1;
                        last_handle_in = last_handle_ff + 1'b1;
                        live_count_in  = live_count_ff + 1'b1;
                        res_status_in  = STS_OK;
                        res_handle_in  = last_handle_ff + 1'b1;
                     end else begin
                        res_status_in = STS_FULL;
                     end
                  end
                  OP_REMOVE: begin
                     if (scan_sts.hit) begin
                        scan_cmd.clr  = 1'b1;
                        res_status_in = STS_OK;
                        if (live_count_ff != '0) begin
                           live_count_in = live_count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     if (scan_sts.hit) begin
                        ram_rd_en = 1'b1;
                        state_in  = ST_READ;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            res_status_in          = STS_OK;
            {res_size_in, res_payload_in} = ram_rd_data;
            state_in               = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_data_in   = TDATA_W'({res_size_ff, res_payload_ff, res_handle_ff});
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         max_entries_ff <= MAX_ENTRIES_RST;
         last_handle_ff <= '0;
         live_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         max_entries_ff <= max_entries_in;
         last_handle_ff <= last_handle_in;
         live_count_ff  <= live_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff          <= op_in;
      in_payload_ff  <= in_payload_in;
      in_size_ff     <= in_size_in;
      res_status_ff  <= res_status_in;
      res_handle_ff  <= res_handle_in;
      res_payload_ff <= res_payload_in;
      res_size_ff    <= res_size_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_status_ff  <= rsp_status_in;
   end

`ifndef SYNTH
   a_live_count_bounded: assert property (@(posedge clock) disable iff (reset)
      live_count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("live count above table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("ready right after an accepted beat");

   a_scan_done_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_sts.done |-> state_ff == ST_SCAN)
      else $error("scan finished outside the scan state");

   a_add_beat_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff[HANDLE_WIDTH-1:0] != '0)
      |-> (rsp_status_ff == STS_OK) && (rsp_data_ff[TDATA_W-1:PL_LO] == '0))
      else $error("issued handle beat carries status or lookup data");
`endif

endmodule

// ===== sv/hta_ram.sv =====
// generic single-write, registered-read ram
module hta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/hta_scan.sv =====
// slot scanner: valid bits, handle tags and one shared slot comparator
module hta_scan
   import hta_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  hta_scan_cmd_type cmd,
   output hta_scan_sts_type sts
);

   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic [HANDLE_WIDTH-1:0] tag_ff [TABLE_DEPTH];
   logic                    busy_ff, busy_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    free_mode_ff, free_mode_in;
   logic [HANDLE_WIDTH-1:0] key_ff, key_in;

   logic cur_valid;
   logic match;
   logic last;

   always_comb begin
      cur_valid = valid_ff[idx_ff];
      match     = free_mode_ff ? !cur_valid
                               : (cur_valid && (tag_ff[idx_ff] == key_ff) && (key_ff != '0));
      last      = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
      sts.done  = busy_ff && (match || last);
      sts.hit   = busy_ff && match;
      sts.slot  = idx_ff;
   end

   always_comb begin
      valid_in     = valid_ff;
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      free_mode_in = free_mode_ff;
      key_in       = key_ff;
      if (cmd.set) begin
         valid_in[cmd.slot] = 1'b1;
      end
      if (cmd.clr) begin
         valid_in[cmd.slot] = 1'b0;
      end
      priority if (cmd.start) begin
         busy_in      = 1'b1;
         idx_in       = '0;
         free_mode_in = cmd.free_mode;
         key_in       = cmd.key;
      end else if (sts.done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= busy_in;
      end
      idx_ff       <= idx_in;
      free_mode_ff <= free_mode_in;
      key_ff       <= key_in;
      if (cmd.set) begin
         tag_ff[cmd.slot] <= cmd.set_handle;
      end
   end

`ifndef SYNTH
   a_hit_in_free_mode_is_empty: assert property (@(posedge clock) disable iff (reset)
      sts.hit && free_mode_ff |-> !valid_ff[sts.slot])
      else $error("free scan hit on a live slot");

   a_hit_in_key_mode_is_live: assert property (@(posedge clock) disable iff (reset)
      sts.hit && !free_mode_ff |-> valid_ff[sts.slot] && (key_ff != '0))
      else $error("handle scan hit on a dead slot or zero key");

   a_done_ends_scan: assert property (@(posedge clock) disable iff (reset)
      sts.done && !cmd.start |=> !busy_ff)
      else $error("scan still busy after done");
`endif

endmodule

// ===== sim/handle_table_allocator_checker.sv =====
// response checker for the handle table allocator: mirrors the table and compares each rsp beat
module handle_table_allocator_checker
   import hta_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [TDATA_W-1:0]  req_tdata,   // handle, payload, payload_size
   input  logic [OPCODE_W-1:0] req_tuser,   // opcode
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [TDATA_W-1:0]  rsp_tdata,   // result_handle, result_payload, result_size
   input  logic [STATUS_W-1:0] rsp_tuser,   // status
   input  logic                csr_wr_en,
   input  logic [MAX_W-1:0]    csr_wr_data, // max_entries
   output int                  mismatches,
   output int                  pending
);

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [HANDLE_WIDTH-1:0] handle;
      logic [PAYLOAD_W-1:0]    payload;
      logic [SIZE_W-1:0]       size;
   } table_reply_type;

   table_reply_type reply_q[$];

   logic                    slot_live[TABLE_DEPTH];
   logic [HANDLE_WIDTH-1:0] slot_handle[TABLE_DEPTH];
   logic [PAYLOAD_W-1:0]    slot_payload[TABLE_DEPTH];
   logic [SIZE_W-1:0]       slot_size[TABLE_DEPTH];
   logic [HANDLE_WIDTH-1:0] last_issued;
   int                      live_total;
   int                      entry_limit;

   function automatic int find_slot(input logic [HANDLE_WIDTH-1:0] h);
      int hit;
      hit = -1;
      if (h != '0) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (hit < 0 && slot_live[i] && slot_handle[i] == h) begin
               hit = i;
            end
         end
      end
      return hit;
   endfunction

   function automatic table_reply_type apply_request(input logic [OPCODE_W-1:0] op,
                                                     input logic [HANDLE_WIDTH-1:0] h,
                                                     input logic [PAYLOAD_W-1:0] pl,
                                                     input logic [SIZE_W-1:0] sz);
      table_reply_type r;
      int slot;
      r = '{status: STS_NOT_FOUND, handle: '0, payload: '0, size: '0};
      slot = -1;
      case (op)
         OP_ADD: begin
            if (live_total >= entry_limit) begin
               r.status = STS_FULL;
            end else if (last_issued == '1) begin
               r.status = STS_EXHAUSTED;
            end else begin
               for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                  if (!slot_live[i]) begin
                     slot = i;
                  end
               end
               if (slot < 0) begin
                  r.status = STS_FULL;
               end else begin
                  last_issued        = last_issued + 1'b1;
                  slot_live[slot]    = 1'b1;
                  slot_handle[slot]  = last_issued;
                  slot_payload[slot] = pl;
                  slot_size[slot]    = sz;
                  live_total++;
                  r.status = STS_OK;
                  r.handle = last_issued;
               end
            end
         end
         OP_REMOVE: begin
            slot = find_slot(h);
            if (slot >= 0) begin
               slot_live[slot] = 1'b0;
               if (live_total > 0) begin
                  live_total--;
               end
               r.status = STS_OK;
            end
         end
         OP_LOOKUP: begin
            slot = find_slot(h);
            if (slot >= 0) begin
               r.status  = STS_OK;
               r.payload = slot_payload[slot];
               r.size    = slot_size[slot];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_reply();
      table_reply_type want;
      table_reply_type got;
      got.status  = rsp_tuser;
      got.handle  = rsp_tdata[HANDLE_WIDTH-1:0];
      got.payload = rsp_tdata[HANDLE_WIDTH +: PAYLOAD_W];
      got.size    = rsp_tdata[HANDLE_WIDTH + PAYLOAD_W +: SIZE_W];
      if (reply_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("unexpected rsp beat: status %0d handle %0h payload %0h size %0h",
                     got.status, got.handle, got.payload, got.size);
         end
      end else begin
         want = reply_q.pop_front();
         if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("rsp mismatch: status %0d/%0d handle %0h/%0h payload %0h/%0h size %0h/%0h",
                        want.status, got.status, want.handle, got.handle,
                        want.payload, got.payload, want.size, got.size);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reply_q.delete();
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_live[i] = 1'b0;
         end
         last_issued = '0;
         live_total  = 0;
         entry_limit = TABLE_DEPTH;
         mismatches  = 0;
      end else begin
         if (csr_wr_en) begin
            entry_limit = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            reply_q.push_back(apply_request(req_tuser, req_tdata[HANDLE_WIDTH-1:0],
                                            req_tdata[HANDLE_WIDTH +: PAYLOAD_W],
                                            req_tdata[HANDLE_WIDTH + PAYLOAD_W +: SIZE_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            check_reply();
         end
      end
      pending <= reply_q.size();
   end

endmodule

// ===== sim/handle_table_allocator_core_test.sv =====
// testbench top for the handle table allocator: stimulus, idling and verdict
module handle_table_allocator_core_test;
   import hta_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int PHASES = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TDATA_W-1:0]  req_tdata = '0;   // handle, payload, payload_size
   logic [OPCODE_W-1:0] req_tuser = OP_ADD; // opcode
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [TDATA_W-1:0]  rsp_tdata;        // result_handle, result_payload, result_size
   logic [STATUS_W-1:0] rsp_tuser;        // status
   logic                csr_wr_en = 1'b0;
   logic [MAX_W-1:0]    csr_wr_data = '0; // max_entries

   int mismatches;
   int pending;
   int adds_sent = 0;
   int stall_left = 0;
   bit idle_on = 1'b1;

   always #1 clock = ~clock;

   handle_table_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   handle_table_allocator_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   // receiver backpressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [HANDLE_WIDTH-1:0] h,
                            input logic [PAYLOAD_W-1:0] pl, input logic [SIZE_W-1:0] sz);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= TDATA_W'({sz, pl, h});
      do @(posedge clock); while (!req_tready);
      if (op == OP_ADD) begin
         adds_sent++;
      end
   endtask

   task automatic stream_stop();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_limit(input logic [MAX_W-1:0] value);
      stream_stop();
      while (pending != 0) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random(input int add_pct);
      int roll;
      int pick;
      int guess;
      logic [OPCODE_W-1:0]     op;
      logic [HANDLE_WIDTH-1:0] h;
      logic [SIZE_W-1:0]       sz;
      roll  = $urandom_range(0, 99);
      pick  = $urandom_range(0, 19);
      guess = adds_sent - $urandom_range(0, 24);
      if (guess < 1) begin
         guess = 1;
      end
      if (pick < 17) begin
         h = HANDLE_WIDTH'(guess);
      end else if (pick < 19) begin
         h = HANDLE_WIDTH'($urandom);
      end else begin
         h = '0;
      end
      if (roll < add_pct) begin
         op = OP_ADD;
         h  = HANDLE_WIDTH'($urandom);
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: op = OP_REMOVE;
            4, 5, 6, 7: op = OP_LOOKUP;
            8:          op = OP_UNUSED;
            default: begin
               op = OP_LOOKUP;
               h  = HANDLE_WIDTH'($urandom);
            end
         endcase
      end
      case ($urandom_range(0, 9))
         0:       sz = '0;
         1:       sz = '1;
         default: sz = SIZE_W'($urandom);
      endcase
      if (idle_on && $urandom_range(0, 3) == 0) begin
         stream_stop();
         repeat ($urandom_range(0, 8)) @(negedge clock);
      end
      send_item(op, h, $urandom, sz);
   endtask

   initial begin
      #1_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int limits[PHASES];
      limits = '{16, 31, 3, 0, 17, 1, 8, 31, 12, 16};
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // handle zero, unused opcode, size extremes, stale and unknown handles
      send_item(OP_LOOKUP, '0, '0, '0);
      send_item(OP_REMOVE, '0, '1, '1);
      send_item(OP_UNUSED, '1, '1, '1);
      send_item(OP_ADD, '1, '0, '0);
      send_item(OP_ADD, '0, '1, '1);
      send_item(OP_LOOKUP, 31'd1, '0, '0);
      send_item(OP_LOOKUP, 31'd2, '0, '0);
      send_item(OP_LOOKUP, '1, '0, '0);
      send_item(OP_REMOVE, 31'd2, '0, '0);
      send_item(OP_LOOKUP, 31'd2, '0, '0);
      send_item(OP_REMOVE, 31'd2, '0, '0);
      send_item(OP_REMOVE, '1, '0, '0);

      // small limits and refusals
      write_limit(5'd2);
      send_item(OP_ADD, '0, 32'h1234_5678, 16'h00a5);
      send_item(OP_ADD, '0, 32'h8765_4321, 16'h5a00);
      write_limit(5'd0);
      send_item(OP_ADD, '0, 32'hdead_beef, 16'h0001);
      send_item(OP_LOOKUP, 31'd1, '0, '0);
      write_limit(5'd1);
      send_item(OP_REMOVE, 31'd1, '0, '0);
      send_item(OP_ADD, '0, 32'h0f0f_0f0f, 16'h0f0f);
      send_item(OP_REMOVE, 31'd3, '0, '0);
      send_item(OP_ADD, '0, 32'hf0f0_f0f0, 16'hf0f0);
      send_item(OP_LOOKUP, 31'd4, '0, '0);

      for (int p = 0; p < PHASES; p++) begin
         write_limit(MAX_W'(limits[p]));
         idle_on = (p != 4) && (p != PHASES - 1);
         for (int n = 0; n < 113; n++) begin
            send_random((p % 2 == 0) ? 65 : 35);
         end
      end

      stream_stop();
      while (pending != 0) @(negedge clock);
      repeat (TABLE_DEPTH + 8) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
